[rtl/core/dcbpl_pkg.sv]
// shared types, constants and command/status structs for the bus protection ladder
package dcbpl_pkg;

	localparam int BusTickDividerDef = 5;
	localparam int OvConfirmDef      = 2;
	localparam int GateConfirmDef    = 11;
	localparam int AdcBitsDef        = 12;

	// configuration register indexes
	localparam logic [2:0] REG_FULLSCALE = 3'd0;
	localparam logic [2:0] REG_BRAKE_OFF = 3'd1;
	localparam logic [2:0] REG_BRAKE_ON  = 3'd2;
	localparam logic [2:0] REG_REGEN_ST  = 3'd3;
	localparam logic [2:0] REG_REGEN_FL  = 3'd4;
	localparam logic [2:0] REG_OV_TRIP   = 3'd5;
	localparam logic [2:0] REG_GAIN      = 3'd6;
	localparam logic [2:0] REG_MAX_DUTY  = 3'd7;

	// controller states, one-hot
	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SCALE  = 8'b0000_0010,
		ST_SDIV   = 8'b0000_0100,
		ST_FILT   = 8'b0000_1000,
		ST_REGEN  = 8'b0001_0000,
		ST_RDIV   = 8'b0010_0000,
		ST_TICK   = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic capture;    // latch input item
		logic scale;      // compute scaled numerator
		logic div_start;  // start divider on scale
		logic filt;       // median + filter
		logic regen;      // ov debounce, regen derate select / numerator
		logic rdiv_start; // start divider on regen
		logic rdiv_done;  // take regen quotient
		logic tick;       // per-tick logic and result load
	} dp_cmd_t;

	typedef struct packed {
		logic bus_tick;   // this item samples the bus
		logic valid;      // sample valid
		logic need_rdiv;  // regen needs division
		logic div_busy;
	} dp_sts_t;

endpackage

[rtl/core/dcbpl_div.sv]
// restoring serial divider, one quotient bit per cycle
module dcbpl_div import dcbpl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] num,
	input  logic [16:0] den,
	output logic        busy,
	output logic [47:0] quo
);
	logic [5:0]  cnt_q;
	logic [47:0] quo_q;
	logic [16:0] rem_q;
	logic [16:0] den_q;
	logic [17:0] trial;

	assign trial = {rem_q, quo_q[47]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd48;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// shift one numerator bit into the remainder per step
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], quo_q[47]};
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = quo_q;
endmodule

[rtl/core/dcbpl_datapath.sv]
// datapath: config registers, scaling, median, filter, debounce, derate, chopper
module dcbpl_datapath import dcbpl_pkg::*; #(
	parameter int BUS_TICK_DIVIDER   = BusTickDividerDef,
	parameter int OV_CONFIRM_SAMPLES = OvConfirmDef,
	parameter int GATE_CONFIRM_TICKS = GateConfirmDef,
	parameter int ADC_BITS           = AdcBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [11:0] vbus_code,
	input  logic        vbus_valid,
	input  logic        gate_enabled,
	input  logic        driver_fault,
	input  logic        loop_ready,
	input  logic        clear_request,
	input  logic [15:0] current_limit_ma,
	output logic [11:0] brake_duty,
	output logic        gate_cut,
	output logic        fault_latched,
	output logic        ov_event,
	output logic        driver_fault_event,
	output logic        cleared,
	output logic [15:0] regen_limit_ma,
	output logic [15:0] vbus_filtered_mv
);
	localparam logic [15:0] FullCode = 16'((1 << ADC_BITS) - 1);

	// configuration registers
	logic [15:0] fs_q, boff_q, bon_q, rst_q, rfl_q, ovt_q, gain_q;
	logic [11:0] maxd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= 16'd62700; boff_q <= 16'd26000; bon_q <= 16'd27000;
			rst_q <= 16'd28000; rfl_q <= 16'd29000; ovt_q <= 16'd30000;
			gain_q <= 16'd4096; maxd_q <= 12'd2048;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FULLSCALE: fs_q   <= cfg_data;
				REG_BRAKE_OFF: boff_q <= cfg_data;
				REG_BRAKE_ON:  bon_q  <= cfg_data;
				REG_REGEN_ST:  rst_q  <= cfg_data;
				REG_REGEN_FL:  rfl_q  <= cfg_data;
				REG_OV_TRIP:   ovt_q  <= cfg_data;
				REG_GAIN:      gain_q <= cfg_data;
				REG_MAX_DUTY:  maxd_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic [11:0] code_q;
	logic        vld_q, gen_q, drf_q, rdy_q, clr_q;
	logic [15:0] lim_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			code_q <= vbus_code; vld_q <= vbus_valid; gen_q <= gate_enabled;
			drf_q <= driver_fault; rdy_q <= loop_ready; clr_q <= clear_request;
			lim_q <= current_limit_ma;
		end
	end

	// state
	logic [15:0] older_q, newer_q, filt_q, held_q;
	logic        primed_q, chop_q, fault_q;
	logic [1:0]  ovc_q;
	logic [3:0]  gfc_q;
	logic [2:0]  tdiv_q;
	logic [31:0] prod_q;

	// serial divider for the regen derate
	logic        div_start, div_busy;
	logic [47:0] div_num, div_quo;
	logic [16:0] div_den;
	logic [31:0] rprod;

	assign rprod = 32'(lim_q) * 32'(rfl_q - filt_q);

	dcbpl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .busy(div_busy), .quo(div_quo)
	);

	assign div_start = cmd.rdiv_start;
	assign div_num   = {16'd0, rprod};
	assign div_den   = {1'b0, rfl_q - rst_q};

	// scaling division by the full-scale code: fold the high part back into the low part
	logic [31:0] sacc_q, squo_q, shi;
	logic        sbusy_q;

	assign shi = sacc_q >> ADC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbusy_q <= 1'b0;
		end else if (cmd.div_start) begin
			sbusy_q <= 1'b1;
		end else if (sbusy_q && shi == '0) begin
			sbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			sacc_q <= prod_q + 32'(FullCode >> 1);
			squo_q <= '0;
		end else if (sbusy_q) begin
			if (shi != '0) begin
				squo_q <= squo_q + shi;
				sacc_q <= (sacc_q & 32'(FullCode)) + shi;
			end else if (sacc_q == 32'(FullCode)) begin
				squo_q <= squo_q + 32'd1;
				sacc_q <= '0;
			end
		end
	end

	logic [2:0] tdiv_inc;
	assign tdiv_inc = tdiv_q + 3'd1;

	assign sts.bus_tick  = (32'(tdiv_inc) >= 32'(BUS_TICK_DIVIDER));
	assign sts.valid     = vld_q;
	assign sts.need_rdiv = (filt_q > rst_q) && (rfl_q > rst_q) && (filt_q < rfl_q);
	assign sts.div_busy  = div_busy | sbusy_q;

	// median of three on current history plus new sample
	logic [15:0] v, o, n, lo, hi, t, med;
	logic signed [17:0] diff;
	logic signed [25:0] p;
	logic signed [17:0] q;
	logic [15:0] fnew;

	always_comb begin
		v   = squo_q[15:0];
		o   = primed_q ? older_q : v;
		n   = primed_q ? newer_q : v;
		lo  = (o < n) ? o : n;
		hi  = (o < n) ? n : o;
		t   = (hi < v) ? hi : v;
		med = (lo > t) ? lo : t;
		diff = $signed({2'b0, med}) - $signed({2'b0, filt_q});
		p    = 26'(diff) * 26'sd84 + 26'sd128;
		q    = 18'(p >>> 8);
		fnew = (filt_q == 16'd0) ? med : 16'($signed({2'b0, filt_q}) + q);
	end

	// per-tick combinational evaluation
	logic       clr_f, gfc_fire, en_g, act;
	logic [3:0] gfc_n;
	logic [31:0] dprod;
	logic [15:0] dshift;
	logic        chop_n;
	logic [11:0] duty;

	always_comb begin
		gfc_n = (gen_q && drf_q) ?
			((32'(gfc_q) < GATE_CONFIRM_TICKS) ? gfc_q + 4'd1 : gfc_q) : 4'd0;
		gfc_fire = (32'(gfc_n) >= GATE_CONFIRM_TICKS);
		en_g = gen_q & ~gfc_fire;
		clr_f = fault_q | gfc_fire;
		act = rdy_q & ~clr_f & en_g & (filt_q != 16'd0);
		chop_n = chop_q;
		if (!act) begin
			chop_n = 1'b0;
		end else begin
			if (filt_q < boff_q) chop_n = 1'b0;
			if (filt_q > bon_q)  chop_n = 1'b1;
		end
		dprod  = 32'(filt_q - boff_q) * 32'(gain_q);
		dshift = dprod[31:16];
		duty = '0;
		if (act && chop_n && filt_q > boff_q) begin
			duty = (dshift > 16'(maxd_q)) ? maxd_q : dshift[11:0];
		end
	end

	logic ovc_fire;
	logic [1:0] ovc_n;
	logic [15:0] vb;
	assign vb = filt_q;
	always_comb begin
		ovc_n = (vb > ovt_q) ?
			((32'(ovc_q) < OV_CONFIRM_SAMPLES) ? ovc_q + 2'd1 : ovc_q) : 2'd0;
		ovc_fire = (32'(ovc_n) >= OV_CONFIRM_SAMPLES);
	end

	// state registers and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= '0; newer_q <= '0; filt_q <= '0; held_q <= '0;
			primed_q <= 1'b0; chop_q <= 1'b0; fault_q <= 1'b0;
			ovc_q <= '0; gfc_q <= '0; tdiv_q <= '0;
			gate_cut <= 1'b0; ov_event <= 1'b0; driver_fault_event <= 1'b0;
			cleared <= 1'b0; brake_duty <= '0;
		end else begin
			if (cmd.capture) begin
				if (clear_request) fault_q <= 1'b0;
				gate_cut <= 1'b0;
				ov_event <= 1'b0;
			end
			if (cmd.scale) begin
				tdiv_q <= sts.bus_tick ? 3'd0 : tdiv_inc;
			end
			if (cmd.filt) begin
				if (vld_q) begin
					older_q <= n; newer_q <= v; primed_q <= 1'b1;
					filt_q <= fnew;
				end
			end
			if (cmd.regen && filt_q != 16'd0) begin
				ovc_q <= ovc_n;
				if (ovc_fire && !fault_q) begin
					fault_q <= 1'b1; gate_cut <= 1'b1; ov_event <= 1'b1;
				end
				if (filt_q <= rst_q) held_q <= lim_q;
				else if (!sts.need_rdiv) held_q <= '0;
			end
			if (cmd.rdiv_done) held_q <= div_quo[15:0];
			if (cmd.tick) begin
				gfc_q <= gfc_n;
				if (gfc_fire) begin
					fault_q <= 1'b1; gate_cut <= 1'b1;
				end
				driver_fault_event <= gfc_fire;
				cleared <= clr_q;
				chop_q <= chop_n;
				brake_duty <= duty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scale) prod_q <= 32'(code_q > FullCode[11:0] && ADC_BITS < 12 ?
			FullCode : 16'(code_q)) * 32'(fs_q);
	end

	assign fault_latched    = fault_q;
	assign regen_limit_ma   = held_q;
	assign vbus_filtered_mv = filt_q;
endmodule

[rtl/core/dcbpl_ctrl.sv]
// controller state machine sequencing one tick
module dcbpl_ctrl import dcbpl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	state_t state_q, state_d;
	logic   started_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			started_q <= (state_d == state_q);
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = (sts.bus_tick && sts.valid) ? ST_SDIV :
					(sts.bus_tick ? ST_REGEN : ST_TICK);
			end
			ST_SDIV: begin
				if (!started_q) cmd.div_start = 1'b1;
				else if (!sts.div_busy) state_d = ST_FILT;
			end
			ST_FILT: begin
				cmd.filt = 1'b1;
				state_d = ST_REGEN;
			end
			ST_REGEN: begin
				cmd.regen = 1'b1;
				state_d = sts.need_rdiv ? ST_RDIV : ST_TICK;
			end
			ST_RDIV: begin
				if (!started_q) cmd.rdiv_start = 1'b1;
				else if (!sts.div_busy) begin
					cmd.rdiv_done = 1'b1;
					state_d = ST_TICK;
				end
			end
			ST_TICK: begin
				cmd.tick = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

[rtl/core/dc_bus_protection_ladder.sv]
// top level of the dc bus protection ladder
// sequence: a tick without bus sample passes the scale, tick and out steps; a sample tick with
// an invalid sample adds the regen step; a valid sample also runs the scaling folds and the
// filter step, and the serial divider runs when the regen limit needs it
// throughput: a new item is taken only once the previous result has been taken at the output
// reset: arst_n clears the control, filter and result state and loads register defaults
module dc_bus_protection_ladder import dcbpl_pkg::*; #(
	parameter int BUS_TICK_DIVIDER   = BusTickDividerDef,
	parameter int OV_CONFIRM_SAMPLES = OvConfirmDef,
	parameter int GATE_CONFIRM_TICKS = GateConfirmDef,
	parameter int ADC_BITS           = AdcBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] vbus_code,
	input  logic        vbus_valid,
	input  logic        gate_enabled,
	input  logic        driver_fault,
	input  logic        loop_ready,
	input  logic        clear_request,
	input  logic [15:0] current_limit_ma,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] brake_duty,
	output logic        gate_cut,
	output logic        fault_latched,
	output logic        ov_event,
	output logic        driver_fault_event,
	output logic        cleared,
	output logic [15:0] regen_limit_ma,
	output logic [15:0] vbus_filtered_mv
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	dcbpl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	dcbpl_datapath #(
		.BUS_TICK_DIVIDER(BUS_TICK_DIVIDER), .OV_CONFIRM_SAMPLES(OV_CONFIRM_SAMPLES),
		.GATE_CONFIRM_TICKS(GATE_CONFIRM_TICKS), .ADC_BITS(ADC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.vbus_code(vbus_code), .vbus_valid(vbus_valid), .gate_enabled(gate_enabled),
		.driver_fault(driver_fault), .loop_ready(loop_ready),
		.clear_request(clear_request), .current_limit_ma(current_limit_ma),
		.brake_duty(brake_duty), .gate_cut(gate_cut), .fault_latched(fault_latched),
		.ov_event(ov_event), .driver_fault_event(driver_fault_event),
		.cleared(cleared), .regen_limit_ma(regen_limit_ma),
		.vbus_filtered_mv(vbus_filtered_mv)
	);
endmodule

[rtl/core/dcbpl_checker.sv]
// port-level checker for the bus protection ladder, bound to the top level
module dcbpl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       ov_event,
	input logic       gate_cut,
	input logic       fault_latched,
	input logic [11:0] brake_duty
);
	// no new transfer while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	// an accepted input makes the block busy
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("ready right after input");
	// an over-voltage event always cuts the gate and latches
	a_ov_cut: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ov_event) |-> (gate_cut && fault_latched))
		else $error("ov event without cut");
	// latched fault forces the chopper off
	a_fault_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fault_latched) |-> (brake_duty == 12'd0))
		else $error("duty while faulted");
	// result holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(brake_duty)))
		else $error("result changed while stalled");
endmodule

bind dc_bus_protection_ladder dcbpl_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .ov_event(ov_event),
	.gate_cut(gate_cut), .fault_latched(fault_latched), .brake_duty(brake_duty)
);
